>>> rtl/core/gea_pkg.sv
// shared types and constants for the gather address generator
package gea_pkg;

    // default geometry
    localparam int GEA_MAX_DIMS  = 4;
    localparam int GEA_DIM_BITS  = 16;
    localparam int GEA_ADDR_BITS = 32;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register map
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS    = 3'd0,
        CFG_GATHER_AXIS = 3'd1,
        CFG_IN_DIMS     = 3'd2,
        CFG_OUT_DIMS    = 3'd3,
        CFG_INDEX_WIDE  = 3'd4
    } t_cfg_idx;

    // register reset values
    localparam logic [2:0]  NUM_DIMS_RST    = 3'd1;
    localparam logic [2:0]  GATHER_AXIS_RST = 3'd0;
    localparam logic [63:0] DIMS_RST        = 64'h0001_0001_0001_0001;
    localparam logic        INDEX_WIDE_RST  = 1'b0;

    // per-beat sideband carried with each element
    typedef struct packed {
        logic [31:0] position;
        logic        fixed;
        logic        last;
    } t_tag;

    // queue status seen by front, back and the top level
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_qstat;

endpackage

>>> rtl/core/gather_elements_address_gen.sv
// top level of the gather source-address generator
// throughput: one beat per cycle while the output is not stalled;
// the first back stage starts the sum; each later one holds one multiply-add
// the front can run up to QUEUE_DEPTH beats ahead while the output is stalled
// reset (synchronous, active low) zeroes the odometer, position counter and queue
// and loads the register defaults: one dimension, axis 0, all extents one
module gather_elements_address_gen
    import gea_pkg::*;
#(
    parameter int MAX_DIMS  = GEA_MAX_DIMS,
    parameter int DIM_BITS  = GEA_DIM_BITS,
    parameter int ADDR_BITS = GEA_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    // index channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [63:0]   i_index_value,
    // address channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_source_address,
    output logic [31:0]          o_out_position,
    output logic                 o_index_fixed,
    output logic                 o_last_element
);

    localparam int CW = MAX_DIMS * DIM_BITS;
    localparam int QW = CW + MAX_DIMS + $bits(t_tag);

    logic [2:0]          r_num_dims;
    logic signed [2:0]   r_gather_axis;
    logic [63:0]         r_in_dims;
    logic [63:0]         r_out_dims;
    logic                r_index_wide;

    logic [CW-1:0]       in_ext;
    logic [CW-1:0]       out_ext;

    logic                push;
    logic                pop;
    logic [CW-1:0]       f_coords;
    logic [MAX_DIMS-1:0] f_used;
    t_tag                f_tag;
    logic [QW-1:0]       q_rdata;
    t_qstat              q_stat;
    logic [CW-1:0]       b_coords;
    logic [MAX_DIMS-1:0] b_used;
    t_tag                b_tag;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims    <= NUM_DIMS_RST;
            r_gather_axis <= GATHER_AXIS_RST;
            r_in_dims     <= DIMS_RST;
            r_out_dims    <= DIMS_RST;
            r_index_wide  <= INDEX_WIDE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NUM_DIMS:    r_num_dims    <= i_cfg_data[2:0];
                CFG_GATHER_AXIS: r_gather_axis <= i_cfg_data[2:0];
                CFG_IN_DIMS:     r_in_dims     <= i_cfg_data;
                CFG_OUT_DIMS:    r_out_dims    <= i_cfg_data;
                CFG_INDEX_WIDE:  r_index_wide  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // extent fields; anything past bit 63 reads as zero
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_ext
        localparam int LO = d * DIM_BITS;
        if (LO + DIM_BITS <= 64) begin : g_full
            assign in_ext[LO +: DIM_BITS]  = r_in_dims[LO +: DIM_BITS];
            assign out_ext[LO +: DIM_BITS] = r_out_dims[LO +: DIM_BITS];
        end else if (LO < 64) begin : g_part
            assign in_ext[LO +: DIM_BITS]  = DIM_BITS'(r_in_dims[63:LO]);
            assign out_ext[LO +: DIM_BITS] = DIM_BITS'(r_out_dims[63:LO]);
        end else begin : g_none
            assign in_ext[LO +: DIM_BITS]  = '0;
            assign out_ext[LO +: DIM_BITS] = '0;
        end
    end

    // front: classify index and step the odometer
    gea_front #(
        .MAX_DIMS (MAX_DIMS),
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_num_dims    (r_num_dims),
        .i_gather_axis (r_gather_axis),
        .i_index_wide  (r_index_wide),
        .i_in_ext      (in_ext),
        .i_out_ext     (out_ext),
        .i_in_valid    (i_in_valid),
        .i_index_value (i_index_value),
        .i_q_stat      (q_stat),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_coords      (f_coords),
        .o_used        (f_used),
        .o_tag         (f_tag)
    );

    // decoupling queue
    gea_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_coords, f_used, f_tag}),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    assign {b_coords, b_used, b_tag} = q_rdata;

    // back: address arithmetic and output register
    gea_back #(
        .MAX_DIMS  (MAX_DIMS),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_ext         (in_ext),
        .i_q_stat         (q_stat),
        .i_coords         (b_coords),
        .i_used           (b_used),
        .i_tag            (b_tag),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_source_address (o_source_address),
        .o_out_position   (o_out_position),
        .o_index_fixed    (o_index_fixed),
        .o_last_element   (o_last_element)
    );

    // queue occupancy never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // a full queue holds off the index channel
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> o_in_stall)
        else $error("index beat possible while queue full");

    // the beat after a final element restarts at position zero
    a_wrap_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && $past(push) && $past(f_tag.last) && $past(i_rst_n)
            |-> f_tag.position == '0)
        else $error("position did not wrap after last element");

    // the back end never pops an empty queue
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty && (q_stat.count != '0))
        else $error("pop from empty queue");

endmodule

>>> rtl/core/gea_queue.sv
// short fifo between the classifying front and the address back end
module gea_queue
    import gea_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output t_qstat           o_stat
);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // occupancy update
    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_rdata      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

>>> rtl/core/gea_front.sv
// front end: index fix-up, output odometer and position counter
module gea_front
    import gea_pkg::*;
#(
    parameter int MAX_DIMS = GEA_MAX_DIMS,
    parameter int DIM_BITS = GEA_DIM_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [2:0]                   i_num_dims,
    input  logic signed [2:0]            i_gather_axis,
    input  logic                         i_index_wide,
    input  logic [MAX_DIMS*DIM_BITS-1:0] i_in_ext,
    input  logic [MAX_DIMS*DIM_BITS-1:0] i_out_ext,
    input  logic                         i_in_valid,
    input  logic signed [63:0]           i_index_value,
    input  t_qstat                       i_q_stat,
    output logic                         o_in_stall,
    output logic                         o_push,
    output logic [MAX_DIMS*DIM_BITS-1:0] o_coords,
    output logic [MAX_DIMS-1:0]          o_used,
    output t_tag                         o_tag
);

    localparam int AXW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [DIM_BITS-1:0] r_coord [MAX_DIMS];
    logic [DIM_BITS-1:0] n_coord [MAX_DIMS];
    logic [31:0]         r_position;
    logic [31:0]         n_position;
    logic [AXW-1:0]      axis;
    logic [MAX_DIMS-1:0] used;
    logic [DIM_BITS-1:0] ext_ax;
    logic [63:0]         g_sel;
    logic [63:0]         g_adj;
    logic                fixed;
    logic [DIM_BITS-1:0] g_dim;
    logic                wrap;

    // dimension count and axis clamping
    always_comb begin
        int nd_i;
        int ax_i;
        nd_i = int'(i_num_dims);
        if (nd_i < 1) begin
            nd_i = 1;
        end
        if (nd_i > MAX_DIMS) begin
            nd_i = MAX_DIMS;
        end
        ax_i = int'(i_gather_axis);
        if (ax_i < 0) begin
            ax_i = ax_i + nd_i;
        end
        if (ax_i < 0) begin
            ax_i = 0;
        end
        if (ax_i >= nd_i) begin
            ax_i = nd_i - 1;
        end
        axis = AXW'(ax_i);
        for (int d = 0; d < MAX_DIMS; d++) begin
            used[d] = (d < nd_i);
        end
    end

    assign ext_ax = i_in_ext[axis*DIM_BITS +: DIM_BITS];

    // index: narrow sign extension, one wrap by the extent, range check
    always_comb begin
        g_sel = i_index_wide ? i_index_value
                             : {{32{i_index_value[31]}}, i_index_value[31:0]};
        g_adj = g_sel[63] ? (g_sel + 64'(ext_ax)) : g_sel;
        fixed = g_adj[63] || (g_adj >= 64'(ext_ax));
        g_dim = fixed ? '0 : g_adj[DIM_BITS-1:0];
    end

    // odometer step, innermost dimension first
    always_comb begin
        logic                carry;
        logic [DIM_BITS-1:0] ext;
        logic [DIM_BITS:0]   inc;
        carry = 1'b1;
        ext   = '0;
        inc   = '0;
        for (int d = MAX_DIMS - 1; d >= 0; d--) begin
            n_coord[d] = r_coord[d];
            ext = i_out_ext[d*DIM_BITS +: DIM_BITS];
            if (ext == '0) begin
                ext = DIM_BITS'(1);
            end
            inc = {1'b0, r_coord[d]} + (DIM_BITS+1)'(1);
            if (used[d] && carry) begin
                if (inc >= {1'b0, ext}) begin
                    n_coord[d] = '0;
                end else begin
                    n_coord[d] = inc[DIM_BITS-1:0];
                    carry      = 1'b0;
                end
            end
        end
        wrap       = carry;
        n_position = carry ? '0 : (r_position + 32'd1);
    end

    // odometer and counter registers advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_coord[d] <= '0;
            end
            r_position <= '0;
        end else if (o_push) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_coord[d] <= n_coord[d];
            end
            r_position <= n_position;
        end
    end

    // work item towards the queue
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            o_coords[d*DIM_BITS +: DIM_BITS] = (AXW'(d) == axis) ? g_dim : r_coord[d];
        end
    end

    assign o_used       = used;
    assign o_tag.position = r_position;
    assign o_tag.fixed  = fixed;
    assign o_tag.last   = wrap;
    assign o_in_stall   = i_q_stat.full;
    assign o_push       = i_in_valid && !i_q_stat.full;

endmodule

>>> rtl/core/gea_back.sv
// back end: row-major address by one stride multiply per stage after the first
module gea_back
    import gea_pkg::*;
#(
    parameter int MAX_DIMS  = GEA_MAX_DIMS,
    parameter int DIM_BITS  = GEA_DIM_BITS,
    parameter int ADDR_BITS = GEA_ADDR_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [MAX_DIMS*DIM_BITS-1:0] i_in_ext,
    input  t_qstat                       i_q_stat,
    input  logic [MAX_DIMS*DIM_BITS-1:0] i_coords,
    input  logic [MAX_DIMS-1:0]          i_used,
    input  t_tag                         i_tag,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [31:0]                  o_source_address,
    output logic [31:0]                  o_out_position,
    output logic                         o_index_fixed,
    output logic                         o_last_element
);

    localparam int LAST = MAX_DIMS - 1;

    logic [MAX_DIMS-1:0]          r_vld;
    logic [ADDR_BITS-1:0]         r_acc  [MAX_DIMS];
    logic [MAX_DIMS*DIM_BITS-1:0] r_crd  [MAX_DIMS];
    logic [MAX_DIMS-1:0]          r_used [MAX_DIMS];
    t_tag                         r_tag  [MAX_DIMS];
    logic                         en;

    // whole pipe moves when the output slot is free or being taken
    assign en    = !r_vld[LAST] || !i_out_stall;
    assign o_pop = en && !i_q_stat.empty;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld[0] <= !i_q_stat.empty;
            for (int k = 1; k < MAX_DIMS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // first stage: outermost coordinate starts the sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_acc[0]  <= ADDR_BITS'(i_coords[DIM_BITS-1:0]);
            r_crd[0]  <= i_coords;
            r_used[0] <= i_used;
            r_tag[0]  <= i_tag;
        end
    end

    // later stages: acc * extent + coordinate, skipped for unused dims
    for (genvar k = 1; k < MAX_DIMS; k++) begin : g_stage
        logic [ADDR_BITS+DIM_BITS-1:0] prod;
        logic [ADDR_BITS-1:0]          n_acc;

        always_comb begin
            prod = {{DIM_BITS{1'b0}}, r_acc[k-1]}
                 * {{ADDR_BITS{1'b0}}, i_in_ext[k*DIM_BITS +: DIM_BITS]};
            if (r_used[k-1][k]) begin
                n_acc = prod[ADDR_BITS-1:0]
                      + ADDR_BITS'(r_crd[k-1][k*DIM_BITS +: DIM_BITS]);
            end else begin
                n_acc = r_acc[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_acc[k]  <= n_acc;
                r_crd[k]  <= r_crd[k-1];
                r_used[k] <= r_used[k-1];
                r_tag[k]  <= r_tag[k-1];
            end
        end
    end

    assign o_out_valid      = r_vld[LAST];
    assign o_source_address = 32'(r_acc[LAST]);
    assign o_out_position   = r_tag[LAST].position;
    assign o_index_fixed    = r_tag[LAST].fixed;
    assign o_last_element   = r_tag[LAST].last;

endmodule

>>> tb/gather_elements_address_gen_test.sv
// self-checking testbench for the gather source-address generator
`timescale 1ns / 100ps

module gather_elements_address_gen_test;
    import gea_pkg::*;

    // one address beat as the block should produce it
    typedef struct packed {
        logic [31:0] address;
        logic [31:0] position;
        logic        fixed;
        logic        last;
    } t_addr_beat;

    // receiver stall patterns
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [63:0]   i_index_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [31:0]          o_source_address;
    logic [31:0]          o_out_position;
    logic                 o_index_fixed;
    logic                 o_last_element;

    // register shadows, odometer and position counter of the predictor
    logic [2:0]               reg_num_dims   = NUM_DIMS_RST;
    logic signed [2:0]        reg_axis       = GATHER_AXIS_RST;
    logic [63:0]              reg_in_dims    = DIMS_RST;
    logic [63:0]              reg_out_dims   = DIMS_RST;
    logic                     reg_index_wide = INDEX_WIDE_RST;
    logic [GEA_DIM_BITS-1:0]  odo_coord [GEA_MAX_DIMS] = '{default: '0};
    logic [31:0]              odo_position   = '0;

    t_addr_beat pending_addresses [$];
    int         mismatches  = 0;
    int         burst_left  = 0;
    bit         steady_flow = 1'b0;

    gather_elements_address_gen dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_index_value    (i_index_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_source_address (o_source_address),
        .o_out_position   (o_out_position),
        .o_index_fixed    (o_index_fixed),
        .o_last_element   (o_last_element)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // effective dimension count
    function automatic int dims_used();
        if (reg_num_dims == 3'd0) return 1;
        if (int'(reg_num_dims) > GEA_MAX_DIMS) return GEA_MAX_DIMS;
        return int'(reg_num_dims);
    endfunction

    // effective gather axis, clamped into the dimensions in use
    function automatic int axis_used(input int nd);
        int ax;
        ax = int'(reg_axis);
        if (ax < 0) ax += nd;
        if (ax < 0) ax = 0;
        if (ax >= nd) ax = nd - 1;
        return ax;
    endfunction

    function automatic logic [GEA_DIM_BITS-1:0] in_extent(input int d);
        return reg_in_dims[d*GEA_DIM_BITS +: GEA_DIM_BITS];
    endfunction

    function automatic logic [GEA_DIM_BITS-1:0] out_extent(input int d);
        return reg_out_dims[d*GEA_DIM_BITS +: GEA_DIM_BITS];
    endfunction

    function automatic logic [63:0] pack_dims(input int e0, input int e1, input int e2,
                                              input int e3);
        return {16'(e3), 16'(e2), 16'(e1), 16'(e0)};
    endfunction

    // index biased towards the valid range of the current axis
    function automatic logic [63:0] pick_index();
        logic [63:0] ext;
        logic [63:0] v;
        int unsigned kind;
        ext  = 64'(in_extent(axis_used(dims_used())));
        kind = $urandom_range(0, 99);
        v    = {$urandom, $urandom};
        if (ext != 0 && kind < 55)
            v = 64'($urandom_range(0, 32'(ext - 1)));
        else if (ext != 0 && kind < 70)
            v = -64'($urandom_range(1, 32'(ext)));
        else if (kind < 82)
            v = $urandom_range(0, 1) ? ext + 64'($urandom_range(0, 3))
                                     : -(ext + 64'($urandom_range(1, 3)));
        // junk above bit 31 must be ignored for narrow indices
        if (!reg_index_wide && kind < 70 && $urandom_range(0, 1) == 1)
            v[63:32] = $urandom;
        return v;
    endfunction

    // work out the address beat for one index and step the odometer
    task automatic predict_source_address(input logic [63:0] raw);
        int          nd;
        int          ax;
        int          d;
        logic [63:0] g;
        logic [63:0] ext_ax;
        logic [31:0] addr;
        logic [31:0] stride;
        logic [31:0] coord;
        logic [16:0] next_c;
        logic [15:0] e;
        logic        carry;
        t_addr_beat  beat;
        nd     = dims_used();
        ax     = axis_used(nd);
        ext_ax = 64'(in_extent(ax));
        g      = reg_index_wide ? raw : {{32{raw[31]}}, raw[31:0]};
        beat.fixed = 1'b0;
        if (g[63]) g = g + ext_ax;
        if (g[63] || g >= ext_ax) begin
            g = '0;
            beat.fixed = 1'b1;
        end
        // row-major address, highest-numbered dimension in use has unit stride
        addr   = '0;
        stride = 32'd1;
        for (d = nd - 1; d >= 0; d--) begin
            coord  = (d == ax) ? g[31:0] : 32'(odo_coord[d]);
            addr   = addr + coord * stride;
            stride = stride * 32'(in_extent(d));
        end
        // odometer step; a carry out of dimension 0 ends the tensor
        carry = 1'b1;
        for (d = nd - 1; d >= 0 && carry; d--) begin
            e = out_extent(d);
            if (e == 0) e = 16'd1;
            next_c = {1'b0, odo_coord[d]} + 17'd1;
            if (next_c >= {1'b0, e}) begin
                odo_coord[d] = '0;
            end else begin
                odo_coord[d] = next_c[15:0];
                carry = 1'b0;
            end
        end
        beat.address  = addr;
        beat.position = odo_position;
        beat.last     = carry;
        odo_position  = carry ? 32'd0 : odo_position + 32'd1;
        pending_addresses.push_back(beat);
    endtask

    // compare address beats, follow register writes, predict accepted index beats
    always @(posedge i_clk) begin : scoreboard
        t_addr_beat exp_beat;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_addresses.size() == 0) begin
                    $error("address beat with nothing expected: address %0h position %0d",
                           o_source_address, o_out_position);
                    mismatches++;
                end else begin
                    exp_beat = pending_addresses.pop_front();
                    if (o_source_address !== exp_beat.address) begin
                        $error("source_address: expected %0h, got %0h",
                               exp_beat.address, o_source_address);
                        mismatches++;
                    end
                    if (o_out_position !== exp_beat.position) begin
                        $error("out_position: expected %0d, got %0d",
                               exp_beat.position, o_out_position);
                        mismatches++;
                    end
                    if (o_index_fixed !== exp_beat.fixed) begin
                        $error("index_fixed: expected %0b, got %0b",
                               exp_beat.fixed, o_index_fixed);
                        mismatches++;
                    end
                    if (o_last_element !== exp_beat.last) begin
                        $error("last_element: expected %0b, got %0b",
                               exp_beat.last, o_last_element);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_DIMS:    reg_num_dims   = i_cfg_data[2:0];
                    CFG_GATHER_AXIS: reg_axis       = i_cfg_data[2:0];
                    CFG_IN_DIMS:     reg_in_dims    = i_cfg_data;
                    CFG_OUT_DIMS:    reg_out_dims   = i_cfg_data;
                    CFG_INDEX_WIDE:  reg_index_wide = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                predict_source_address(i_index_value);
        end
    end

    // receiver stalls in spans of changing pattern
    initial begin : out_stall_gen
        t_stall_mode mode;
        int          span;
        int          period;
        int          k;
        i_out_stall = 1'b0;
        forever begin
            mode   = t_stall_mode'($urandom_range(0, 3));
            span   = $urandom_range(8, 60);
            period = $urandom_range(2, 5);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                if (steady_flow) begin
                    i_out_stall <= 1'b0;
                end else begin
                    case (mode)
                        STALL_NONE:  i_out_stall <= 1'b0;
                        STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 35);
                        STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 75);
                        default:     i_out_stall <= ((k % period) == 0);
                    endcase
                end
            end
        end
    end

    // one index beat; called at a falling edge, returns at one, valid left high
    task automatic send_index(input logic [63:0] value);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady_flow && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_index_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // register write; only used while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop sending, wait for every expected beat, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_addresses.size() != 0) @(negedge i_clk);
        repeat (GEA_MAX_DIMS + 2) @(negedge i_clk);
    endtask

    // register defaults: one dimension of extent one
    task automatic test_reset_state();
        send_index(64'd0);
        send_index(64'd1);
        send_index(-64'sd1);
        drain();
    endtask

    // index sign handling, range fix-up and both index widths
    task automatic test_index_handling();
        write_reg(CFG_NUM_DIMS, 64'd3);
        write_reg(CFG_GATHER_AXIS, 64'd1);
        write_reg(CFG_IN_DIMS, pack_dims(4, 5, 6, 9));
        write_reg(CFG_OUT_DIMS, pack_dims(2, 2, 3, 1));
        write_reg(CFG_INDEX_WIDE, 64'd0);
        send_index(64'd0);
        send_index(64'd4);
        send_index(64'd5);
        send_index(-64'sd1);
        send_index(-64'sd5);
        send_index(-64'sd6);
        send_index(64'h0000_0000_8000_0000);
        send_index(64'hFFFF_FFFF_0000_0003);
        drain();
        write_reg(CFG_INDEX_WIDE, 64'd1);
        send_index(64'hFFFF_FFFF_0000_0003);
        send_index(64'h8000_0000_0000_0000);
        send_index(64'h7FFF_FFFF_FFFF_FFFF);
        send_index(-64'sd3);
        drain();
    endtask

    // dimension count and axis clamping, zero extents
    task automatic test_axis_clamping();
        // zero dimensions act as one, axis -4 clamps to 0; junk above the field
        write_reg(CFG_NUM_DIMS, 64'hFFFF_FFFF_FFFF_FFF8);
        write_reg(CFG_GATHER_AXIS, 64'hFFFF_FFFF_FFFF_FFFC);
        write_reg(CFG_INDEX_WIDE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_index(64'd2);
        drain();
        // seven dimensions act as four, last axis
        write_reg(CFG_NUM_DIMS, 64'd7);
        write_reg(CFG_GATHER_AXIS, 64'd3);
        write_reg(CFG_IN_DIMS, pack_dims(2, 3, 4, 5));
        write_reg(CFG_OUT_DIMS, pack_dims(2, 2, 2, 2));
        send_index(64'd4);
        send_index(-64'sd2);
        drain();
        // two dimensions: axis -1, -3 and 3
        write_reg(CFG_NUM_DIMS, 64'd2);
        write_reg(CFG_GATHER_AXIS, 64'h7);
        send_index(64'd2);
        drain();
        write_reg(CFG_GATHER_AXIS, 64'h5);
        send_index(64'd1);
        drain();
        write_reg(CFG_GATHER_AXIS, 64'd3);
        send_index(64'd2);
        drain();
        // zero extent on the axis always fixes the index, zero output extents step as one
        write_reg(CFG_GATHER_AXIS, 64'd0);
        write_reg(CFG_IN_DIMS, pack_dims(0, 3, 1, 1));
        write_reg(CFG_OUT_DIMS, 64'd0);
        send_index(64'd0);
        send_index(-64'sd1);
        drain();
    endtask

    // shrinking the output leaves a coordinate past its extent
    task automatic test_coord_overrun();
        write_reg(CFG_NUM_DIMS, 64'd1);
        write_reg(CFG_GATHER_AXIS, 64'd0);
        write_reg(CFG_IN_DIMS, pack_dims(8, 1, 1, 1));
        write_reg(CFG_OUT_DIMS, pack_dims(6, 1, 1, 1));
        repeat (4) send_index(pick_index());
        drain();
        write_reg(CFG_OUT_DIMS, pack_dims(2, 1, 1, 1));
        repeat (2) send_index(pick_index());
        drain();
    endtask

    // largest extents so strides and addresses wrap at 32 bits
    task automatic test_address_wrap();
        write_reg(CFG_NUM_DIMS, 64'd4);
        write_reg(CFG_GATHER_AXIS, 64'd0);
        write_reg(CFG_IN_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_OUT_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
        send_index(64'd65534);
        send_index(64'd65533);
        drain();
    endtask

    // random settings, each followed by a run of random index beats
    task automatic test_random_traffic();
        int          phase;
        int          d;
        int unsigned pick;
        logic [63:0] data;
        logic [63:0] dims;
        for (phase = 0; phase < 13; phase++) begin
            steady_flow = (phase % 4 == 1);
            // dimension count, now and then out of range
            pick = $urandom_range(0, 9);
            data = {$urandom, $urandom};
            data[2:0] = (pick == 8) ? 3'd0 :
                        (pick == 9) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4));
            write_reg(CFG_NUM_DIMS, data);
            data = {$urandom, $urandom};
            write_reg(CFG_GATHER_AXIS, data);
            // input extents, mostly small
            for (d = 0; d < GEA_MAX_DIMS; d++) begin
                pick = $urandom_range(0, 19);
                dims[d*GEA_DIM_BITS +: GEA_DIM_BITS] =
                    (pick == 0) ? 16'd0 :
                    (pick == 1) ? 16'($urandom) :
                    (pick == 2) ? 16'hFFFF : 16'($urandom_range(1, 9));
            end
            if ($urandom_range(0, 3) != 0) write_reg(CFG_IN_DIMS, dims);
            // output extents small so the tensor ends often
            for (d = 0; d < GEA_MAX_DIMS; d++) begin
                pick = $urandom_range(0, 9);
                dims[d*GEA_DIM_BITS +: GEA_DIM_BITS] =
                    (pick == 0) ? 16'd0 :
                    (pick == 1) ? 16'($urandom_range(10, 40)) : 16'($urandom_range(1, 4));
            end
            if ($urandom_range(0, 3) != 0) write_reg(CFG_OUT_DIMS, dims);
            write_reg(CFG_INDEX_WIDE, {$urandom, $urandom});
            // writes to undecoded indexes must change nothing
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                          {$urandom, $urandom});
            repeat (100) send_index(pick_index());
            drain();
        end
        steady_flow = 1'b0;
    endtask

    // reset, test sequence and verdict
    initial begin : run
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_NUM_DIMS;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_index_value = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_state();
        test_index_handling();
        test_axis_clamping();
        test_coord_overrun();
        test_address_wrap();
        test_random_traffic();
        drain();
        if (mismatches == 0 && pending_addresses.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
